[rtl/core/pbsne_pkg.sv]
// Package for the protobuf service name extractor: parser phases, result kinds,
// fixed counts and the result entry type.
// No dependencies.
package pbsne_pkg;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_TAG       = 3'd1,
    PH_LEN       = 3'd2,
    PH_SKIPVAR   = 3'd3,
    PH_SKIPBYTES = 3'd4,
    PH_NAME      = 3'd5,
    PH_DONE      = 3'd6,
    PH_ERROR     = 3'd7
  } phase_t;

  localparam logic [1:0] KIND_NAME  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;
  localparam logic [1:0] KIND_TRUNC = 2'd3;

  // Field numbers that the parser acts on.
  localparam logic [28:0] FIELD_SKIPVAR   = 29'd1;
  localparam logic [28:0] FIELD_SKIPBYTES = 29'd2;
  localparam logic [28:0] FIELD_NAME_A    = 29'd3;
  localparam logic [28:0] FIELD_NAME_B    = 29'd4;

  localparam logic [31:0] FIXED_SKIP   = 32'd8;
  localparam logic [1:0]  NAMES_WANTED = 2'd2;
  localparam logic [7:0]  DOT_CHAR     = 8'h2E;
  localparam logic [7:0]  HEADER_RESET = 8'd8;

  // Register index of header_skip on the configuration port.
  localparam logic REG_HEADER_SKIP = 1'b0;

  // Result queue: four entries, room for the three results of one byte.
  localparam int FifoDepth = 4;

  typedef struct packed {
    logic       last;
    logic [1:0] kind;
    logic [7:0] data;
  } res_t;

endpackage

[rtl/core/protobuf_service_name_extractor_unit.sv]
// Top level of the protobuf service name extractor: tag and varint parser with
// a four-entry result queue and an APB-style register port.
// Depends on pbsne_pkg.
//
//  channel  | direction | transaction content
//  ---------+-----------+-----------------------------------------------
//  s_*      | in        | tdata = in_byte[7:0], tlast = in_last
//  m_*      | out       | tdata = out_byte[7:0], tuser = out_kind[1:0],
//           |           | tlast = out_last
//  apb      | in/out    | register 0 (byte address 0): header_skip[7:0]
//
// Each byte is parsed in the cycle it is accepted; its zero to three results
// enter the result queue at that edge and leave one per cycle while m_tready
// is high. s_tready is high while the queue holds at most one entry, so with
// one result per byte and m_tready high a byte is taken every cycle; bytes
// giving three results drain at one result per cycle while m_tready is high.
// Reset (rst, synchronous): empty queue, header phase, header_skip set to 8.
module protobuf_service_name_extractor_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] in_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic [1:0]  m_tuser,   // [1:0] out_kind
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0]  header_skip;
  pbsne_pkg::phase_t phase, phase_next;
  logic [31:0] byte_count, byte_count_next;
  logic [31:0] varint_acc, varint_acc_next;
  logic [3:0]  varint_group, varint_group_next;
  logic        is_field3, is_field3_next;
  logic [1:0]  names_found, names_found_next;

  pbsne_pkg::res_t res [0:2];
  logic [1:0]  nres;

  pbsne_pkg::res_t fifo [0:pbsne_pkg::FifoDepth-1];
  logic [1:0]  wr_ptr;
  logic [1:0]  rd_ptr;
  logic [2:0]  count;
  logic        accept;
  logic        pop;

  // Configuration port.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_skip <= pbsne_pkg::HEADER_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == pbsne_pkg::REG_HEADER_SKIP) begin
      header_skip <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == pbsne_pkg::REG_HEADER_SKIP) ? {24'd0, header_skip} : 32'd0;

  // Parser: one byte of work between the state registers and the queue.
  always_comb begin
    pbsne_pkg::phase_t ph;
    logic [31:0] acc_in;
    logic [3:0]  grp_in;
    logic [31:0] part;
    logic [31:0] acc_fed;
    logic        vdone;
    logic        fin;
    logic [7:0]  b;

    b = s_tdata;
    phase_next        = phase;
    byte_count_next   = byte_count;
    varint_acc_next   = varint_acc;
    varint_group_next = varint_group;
    is_field3_next    = is_field3;
    names_found_next  = names_found;
    nres = 2'd0;
    fin  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end

    // A lowered header_skip ends the header before this byte is looked at.
    if (phase == pbsne_pkg::PH_HEADER && byte_count >= {24'd0, header_skip}) begin
      ph = pbsne_pkg::PH_TAG;
      acc_in = 32'd0;
      grp_in = 4'd0;
    end else begin
      ph = phase;
      acc_in = varint_acc;
      grp_in = varint_group;
    end

    // Varint step: bit 7 is the continuation flag and never enters the value.
    case (grp_in)
      4'd0:    part = {25'd0, b[6:0]};
      4'd1:    part = {18'd0, b[6:0], 7'd0};
      4'd2:    part = {11'd0, b[6:0], 14'd0};
      4'd3:    part = {4'd0, b[6:0], 21'd0};
      4'd4:    part = {b[3:0], 28'd0};
      default: part = 32'd0;
    endcase
    acc_fed = acc_in | part;
    vdone   = !b[7];

    case (ph)
      pbsne_pkg::PH_HEADER: begin
        byte_count_next = byte_count + 32'd1;
        if (byte_count_next >= {24'd0, header_skip}) begin
          phase_next = pbsne_pkg::PH_TAG;
          varint_acc_next = 32'd0;
          varint_group_next = 4'd0;
        end
      end
      pbsne_pkg::PH_TAG, pbsne_pkg::PH_LEN: begin
        varint_acc_next = acc_fed;
        varint_group_next = (grp_in < 4'd15) ? grp_in + 4'd1 : grp_in;
        phase_next = ph;
        if (vdone) begin
          varint_group_next = grp_in;
          if (ph == pbsne_pkg::PH_LEN) begin
            byte_count_next = acc_fed;
            phase_next = pbsne_pkg::PH_NAME;
            fin = (acc_fed == 32'd0);
          end else begin
            case (acc_fed[31:3])
              pbsne_pkg::FIELD_SKIPVAR: begin
                phase_next = pbsne_pkg::PH_SKIPVAR;
                varint_acc_next = 32'd0;
                varint_group_next = 4'd0;
              end
              pbsne_pkg::FIELD_SKIPBYTES: begin
                byte_count_next = pbsne_pkg::FIXED_SKIP;
                phase_next = pbsne_pkg::PH_SKIPBYTES;
              end
              pbsne_pkg::FIELD_NAME_A, pbsne_pkg::FIELD_NAME_B: begin
                is_field3_next = (acc_fed[31:3] == pbsne_pkg::FIELD_NAME_A);
                phase_next = pbsne_pkg::PH_LEN;
                varint_acc_next = 32'd0;
                varint_group_next = 4'd0;
              end
              default: begin
                res[nres] = '{last: 1'b0, kind: pbsne_pkg::KIND_ERROR, data: 8'd0};
                nres = nres + 2'd1;
                phase_next = pbsne_pkg::PH_ERROR;
              end
            endcase
          end
        end
      end
      pbsne_pkg::PH_SKIPVAR: begin
        if (vdone) begin
          phase_next = pbsne_pkg::PH_TAG;
          varint_acc_next = 32'd0;
          varint_group_next = 4'd0;
        end
      end
      pbsne_pkg::PH_SKIPBYTES: begin
        if (byte_count != 32'd0) byte_count_next = byte_count - 32'd1;
        if (byte_count_next == 32'd0) begin
          phase_next = pbsne_pkg::PH_TAG;
          varint_acc_next = 32'd0;
          varint_group_next = 4'd0;
        end
      end
      pbsne_pkg::PH_NAME: begin
        res[nres] = '{last: 1'b0, kind: pbsne_pkg::KIND_NAME, data: b};
        nres = nres + 2'd1;
        if (byte_count != 32'd0) byte_count_next = byte_count - 32'd1;
        fin = (byte_count_next == 32'd0);
      end
      default: begin
      end
    endcase

    // End of a name field: the dot follows a field 3 name.
    if (fin) begin
      if (is_field3_next) begin
        res[nres] = '{last: 1'b0, kind: pbsne_pkg::KIND_NAME, data: pbsne_pkg::DOT_CHAR};
        nres = nres + 2'd1;
      end
      names_found_next = names_found + 2'd1;
      if (names_found_next >= pbsne_pkg::NAMES_WANTED) begin
        res[nres] = '{last: 1'b0, kind: pbsne_pkg::KIND_DONE, data: 8'd0};
        nres = nres + 2'd1;
        phase_next = pbsne_pkg::PH_DONE;
      end else begin
        phase_next = pbsne_pkg::PH_TAG;
        varint_acc_next = 32'd0;
        varint_group_next = 4'd0;
      end
    end

    if (s_tlast) begin
      if (phase_next != pbsne_pkg::PH_DONE && phase_next != pbsne_pkg::PH_ERROR) begin
        res[nres] = '{last: 1'b0, kind: pbsne_pkg::KIND_TRUNC, data: 8'd0};
        nres = nres + 2'd1;
      end
      phase_next        = pbsne_pkg::PH_HEADER;
      byte_count_next   = 32'd0;
      varint_acc_next   = 32'd0;
      varint_group_next = 4'd0;
      is_field3_next    = 1'b0;
      names_found_next  = 2'd0;
    end

    if (nres != 2'd0) begin
      res[nres - 2'd1].last = 1'b1;
    end
  end

  assign s_tready = (count <= 3'(pbsne_pkg::FifoDepth - 3));
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = (count != 3'd0);
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= pbsne_pkg::PH_HEADER;
      byte_count   <= 32'd0;
      varint_acc   <= 32'd0;
      varint_group <= 4'd0;
      is_field3    <= 1'b0;
      names_found  <= 2'd0;
    end else if (accept) begin
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      varint_acc   <= varint_acc_next;
      varint_group <= varint_group_next;
      is_field3    <= is_field3_next;
      names_found  <= names_found_next;
    end
  end

  // Result queue.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (accept) wr_ptr <= wr_ptr + nres;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + {1'b0, (accept ? nres : 2'd0)} - {2'd0, pop};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (accept && 2'(i) < nres) begin
        fifo[wr_ptr + 2'(i)] <= res[i];
      end
    end
  end

  assign m_tdata = fifo[rd_ptr].data;
  assign m_tuser = fifo[rd_ptr].kind;
  assign m_tlast = fifo[rd_ptr].last;

  // Checks on the parser and the queue.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'(pbsne_pkg::FifoDepth))
    else $error("result queue overfilled");

  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    accept && s_tlast |=> phase == pbsne_pkg::PH_HEADER && names_found == 2'd0)
    else $error("parser not cleared after final byte");

  a_done_names: assert property (@(posedge clk) disable iff (rst)
    phase == pbsne_pkg::PH_DONE |-> names_found == pbsne_pkg::NAMES_WANTED)
    else $error("done reached without both names");

  a_name_count: assert property (@(posedge clk) disable iff (rst)
    phase == pbsne_pkg::PH_NAME |-> byte_count != 32'd0)
    else $error("name phase with no bytes left");

endmodule
